>>> rtl/core/sptmr_pkg.sv
// ----------------------------------------------------------------------------
// sptmr_pkg
// Shared codes, types and state-transition functions of the slot pool
// lifecycle timer.
// ----------------------------------------------------------------------------
`default_nettype none

package sptmr_pkg;

  // Command codes.
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_ALLOC   = 2'd1;
  localparam logic [1:0] CMD_KILL    = 2'd2;
  localparam logic [1:0] CMD_DELAYED = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_POOL_FULL  = 2'd1;
  localparam logic [1:0] ST_TIMER_FULL = 2'd2;

  // Lifecycle states of one slot.
  localparam logic [2:0] LS_FREE       = 3'd0;
  localparam logic [2:0] LS_CREATED    = 3'd1;
  localparam logic [2:0] LS_STARTING   = 3'd2;
  localparam logic [2:0] LS_RUNNING    = 3'd3;
  localparam logic [2:0] LS_KILL_REQ   = 3'd4;
  localparam logic [2:0] LS_DESTROYING = 3'd5;

  // One entry of the delayed-destroy timer table.
  typedef struct packed {
    logic        valid;
    logic [5:0]  target;
    logic [15:0] left;
  } tmr_entry_t;

  // State reached by a slot on a tick.
  function automatic logic [2:0] tick_next(input logic [2:0] cur);
    logic [2:0] nxt;
    case (cur)
      LS_CREATED:    nxt = LS_STARTING;
      LS_STARTING:   nxt = LS_RUNNING;
      LS_RUNNING:    nxt = LS_RUNNING;
      LS_KILL_REQ:   nxt = LS_DESTROYING;
      default:       nxt = LS_FREE;
    endcase
    return nxt;
  endfunction

  // State reached by a slot on a destroy.
  function automatic logic [2:0] kill_next(input logic [2:0] cur);
    logic [2:0] nxt;
    case (cur)
      LS_CREATED, LS_STARTING, LS_RUNNING, LS_KILL_REQ: nxt = LS_KILL_REQ;
      LS_DESTROYING:                                    nxt = LS_DESTROYING;
      default:                                          nxt = LS_FREE;
    endcase
    return nxt;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/slot_pool_lifecycle_timer.sv
// A tick walks every slot, then every timer entry, with an extra destroy step
// for each firing timer whose slot lies inside the pool. Allocate and delayed
// destroy search their memory for a free entry. The result beat is registered,
// comes with busy low and is never stalled. Throughput: one command at a time;
// each memory is walked one entry per cycle, but a timer's destroy step pauses
// the timer walk. Reset: a clearing pass empties both memories with busy held high.
// ----------------------------------------------------------------------------
// slot_pool_lifecycle_timer
// Pool of lifecycle slots with a table of delayed-destroy timers, driven by a
// small sequencer over two on-chip memories.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_pool_lifecycle_timer #(
  parameter int unsigned POOL_SLOTS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command_i,
  input  wire logic [5:0]  slot_i,
  input  wire logic [15:0] delay_i,
  input  wire logic [15:0] elapsed_i,
  output logic             valid_o,
  output logic [1:0]       status_o,
  output logic [5:0]       granted_slot_o,
  output logic [2:0]       slot_state_o
);

  // Address width of both memories, width of the walk counter (it must hold
  // POOL_SLOTS itself) and a compare width that covers slot numbers and the
  // pool size alike.
  localparam int unsigned AW    = $clog2(POOL_SLOTS);
  localparam int unsigned CNT_W = $clog2(POOL_SLOTS + 1);
  localparam int unsigned CW    = ((AW > 6) ? AW : 6) + 1;
  localparam int unsigned TW    = $bits(sptmr_pkg::tmr_entry_t);

  localparam logic [CNT_W-1:0] IDX_LAST = CNT_W'(POOL_SLOTS - 1);
  localparam logic [CNT_W-1:0] IDX_END  = CNT_W'(POOL_SLOTS);
  localparam logic [CNT_W-1:0] IDX_ONE  = CNT_W'(1);
  localparam logic [CW-1:0]    POOL_CW  = CW'(POOL_SLOTS);

  // Sequencer states.
  localparam logic [3:0] S_CLEAR = 4'd0;  // clearing pass after reset
  localparam logic [3:0] S_IDLE  = 4'd1;  // waiting for a command
  localparam logic [3:0] S_TL    = 4'd2;  // tick: advance every slot
  localparam logic [3:0] S_TC    = 4'd3;  // tick: check one timer entry
  localparam logic [3:0] S_TK    = 4'd4;  // tick: destroy a timer's slot
  localparam logic [3:0] S_SR    = 4'd5;  // read the addressed slot
  localparam logic [3:0] S_SH    = 4'd6;  // report the addressed slot
  localparam logic [3:0] S_AL    = 4'd7;  // allocate: search a free slot
  localparam logic [3:0] S_DS    = 4'd8;  // delayed destroy: free timer search
  localparam logic [3:0] S_KL    = 4'd9;  // destroy now: write the slot

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] idx_prev;
  logic [1:0]       status_q, status_d;
  logic [5:0]       slot_q, slot_d;
  logic [15:0]      delay_q, delay_d;
  logic [15:0]      elapsed_q, elapsed_d;

  logic             out_v_q, out_v_d;
  logic [1:0]       out_status_q, out_status_d;
  logic [5:0]       out_slot_q, out_slot_d;
  logic [2:0]       out_state_q, out_state_d;

  // Slot memory port signals.
  logic          l_we, l_re;
  logic [AW-1:0] l_waddr, l_raddr;
  logic [2:0]    l_wdata, l_rdata;

  // Timer memory port signals.
  logic                   t_we, t_re;
  logic [AW-1:0]          t_waddr, t_raddr;
  sptmr_pkg::tmr_entry_t  t_wdata, t_rd;
  logic [TW-1:0]          t_rdata;

  logic          in_pool_i, in_pool_q, tgt_in_pool;
  logic [AW-1:0] slot_addr_i, slot_addr_q, tgt_addr;
  logic [CW-1:0] prev_cw;
  logic          tmr_fire;
  logic          advance;

  sptmr_ram #(
    .WIDTH (3),
    .DEPTH (POOL_SLOTS)
  ) u_life_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .re_i    (l_re),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  sptmr_ram #(
    .WIDTH (TW),
    .DEPTH (POOL_SLOTS)
  ) u_tmr_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .re_i    (t_re),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  assign t_rd = t_rdata;

  // Slot numbers beyond the pool are never used as addresses; the compare is
  // carried out at a width that holds both the slot field and the pool size.
  assign in_pool_i   = (CW'(slot_i) < POOL_CW);
  assign in_pool_q   = (CW'(slot_q) < POOL_CW);
  assign tgt_in_pool = (CW'(t_rd.target) < POOL_CW);
  assign slot_addr_i = AW'(slot_i);
  assign slot_addr_q = AW'(slot_q);
  assign tgt_addr    = AW'(t_rd.target);

  // The memories return read data from a register, so the searches and
  // the slot walk look at the entry one below the counter.
  assign idx_prev = idx_q - IDX_ONE;
  assign prev_cw  = CW'(idx_prev);

  // A live timer fires once the elapsed time covers what is left of it.
  assign tmr_fire = t_rd.valid && (elapsed_q >= t_rd.left);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    status_d     = status_q;
    slot_d       = slot_q;
    delay_d      = delay_q;
    elapsed_d    = elapsed_q;
    out_v_d      = 1'b0;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_state_d  = out_state_q;
    l_we         = 1'b0;
    l_waddr      = idx_q[AW-1:0];
    l_wdata      = sptmr_pkg::LS_FREE;
    l_re         = 1'b0;
    l_raddr      = idx_q[AW-1:0];
    t_we         = 1'b0;
    t_waddr      = idx_q[AW-1:0];
    t_wdata      = '0;
    t_re         = 1'b0;
    t_raddr      = idx_q[AW-1:0];
    advance      = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        l_we  = 1'b1;
        t_we  = 1'b1;
        idx_d = idx_q + IDX_ONE;
        if (idx_q == IDX_LAST) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          slot_d    = slot_i;
          delay_d   = delay_i;
          elapsed_d = elapsed_i;
          status_d  = sptmr_pkg::ST_OK;
          idx_d     = '0;
          case (command_i)
            sptmr_pkg::CMD_TICK:  state_d = S_TL;
            sptmr_pkg::CMD_ALLOC: state_d = S_AL;
            sptmr_pkg::CMD_KILL: begin
              if (in_pool_i) begin
                l_re    = 1'b1;
                l_raddr = slot_addr_i;
                state_d = S_KL;
              end else begin
                out_v_d      = 1'b1;
                out_status_d = sptmr_pkg::ST_OK;
                out_slot_d   = slot_i;
                out_state_d  = sptmr_pkg::LS_FREE;
              end
            end
            default: begin
              if (in_pool_i) begin
                state_d = S_DS;
              end else begin
                out_v_d      = 1'b1;
                out_status_d = sptmr_pkg::ST_OK;
                out_slot_d   = slot_i;
                out_state_d  = sptmr_pkg::LS_FREE;
              end
            end
          endcase
        end
      end

      S_TL: begin
        l_re    = (idx_q != IDX_END);
        l_we    = (idx_q != '0);
        l_waddr = idx_prev[AW-1:0];
        l_wdata = sptmr_pkg::tick_next(l_rdata);
        idx_d   = idx_q + IDX_ONE;
        if (idx_q == IDX_END) begin
          t_re    = 1'b1;
          t_raddr = '0;
          idx_d   = '0;
          state_d = S_TC;
        end
      end

      S_TC: begin
        if (tmr_fire) begin
          t_we    = 1'b1;
          t_wdata = '0;
          if (tgt_in_pool) begin
            l_re    = 1'b1;
            l_raddr = tgt_addr;
            state_d = S_TK;
          end else begin
            advance = 1'b1;
          end
        end else begin
          t_we         = t_rd.valid;
          t_wdata      = t_rd;
          t_wdata.left = t_rd.left - elapsed_q;
          advance      = 1'b1;
        end
      end

      S_TK: begin
        l_we    = 1'b1;
        l_waddr = tgt_addr;
        l_wdata = sptmr_pkg::kill_next(l_rdata);
        advance = 1'b1;
        state_d = S_TC;
      end

      S_SR: begin
        if (in_pool_q) begin
          l_re    = 1'b1;
          l_raddr = slot_addr_q;
          state_d = S_SH;
        end else begin
          out_v_d      = 1'b1;
          out_status_d = status_q;
          out_slot_d   = slot_q;
          out_state_d  = sptmr_pkg::LS_FREE;
          state_d      = S_IDLE;
        end
      end

      S_SH: begin
        out_v_d      = 1'b1;
        out_status_d = status_q;
        out_slot_d   = slot_q;
        out_state_d  = l_rdata;
        state_d      = S_IDLE;
      end

      S_AL: begin
        l_re  = (idx_q != IDX_END);
        idx_d = idx_q + IDX_ONE;
        if ((idx_q != '0) && (l_rdata == sptmr_pkg::LS_FREE)) begin
          l_we         = 1'b1;
          l_waddr      = idx_prev[AW-1:0];
          l_wdata      = sptmr_pkg::LS_CREATED;
          out_v_d      = 1'b1;
          out_status_d = sptmr_pkg::ST_OK;
          out_slot_d   = prev_cw[5:0];
          out_state_d  = sptmr_pkg::LS_CREATED;
          state_d      = S_IDLE;
        end else if (idx_q == IDX_END) begin
          status_d = sptmr_pkg::ST_POOL_FULL;
          state_d  = S_SR;
        end
      end

      S_DS: begin
        t_re  = (idx_q != IDX_END);
        idx_d = idx_q + IDX_ONE;
        if ((idx_q != '0) && !t_rd.valid) begin
          t_we           = 1'b1;
          t_waddr        = idx_prev[AW-1:0];
          t_wdata.valid  = 1'b1;
          t_wdata.target = slot_q;
          t_wdata.left   = delay_q;
          state_d        = S_SR;
        end else if (idx_q == IDX_END) begin
          status_d = sptmr_pkg::ST_TIMER_FULL;
          state_d  = S_SR;
        end
      end

      S_KL: begin
        l_we         = 1'b1;
        l_waddr      = slot_addr_q;
        l_wdata      = sptmr_pkg::kill_next(l_rdata);
        out_v_d      = 1'b1;
        out_status_d = sptmr_pkg::ST_OK;
        out_slot_d   = slot_q;
        out_state_d  = sptmr_pkg::kill_next(l_rdata);
        state_d      = S_IDLE;
      end

      default: begin
        idx_d   = '0;
        state_d = S_CLEAR;
      end
    endcase

    // Step on to the next timer entry, or finish the tick with a read of the
    // addressed slot once the last entry has been handled.
    if (advance) begin
      if (idx_q == IDX_LAST) begin
        state_d = S_SR;
      end else begin
        t_re    = 1'b1;
        t_raddr = idx_q[AW-1:0] + AW'(1);
        idx_d   = idx_q + IDX_ONE;
        state_d = S_TC;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    slot_q       <= slot_d;
    delay_q      <= delay_d;
    elapsed_q    <= elapsed_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_state_q  <= out_state_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign valid_o        = out_v_q;
  assign status_o       = out_status_q;
  assign granted_slot_o = out_slot_q;
  assign slot_state_o   = out_state_q;

  // An accepted tick always sets the sequencer busy.
  a_tick_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (command_i == sptmr_pkg::CMD_TICK) |=> busy)
    else $error("tick accepted without the sequencer going busy");

  // Every result beat is issued while the sequencer is idle.
  a_beat_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result beat while the sequencer is still working");

  // Neither memory is written while the block waits for a command.
  a_no_idle_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !l_we && !t_we)
    else $error("memory write while idle");

endmodule

`default_nettype wire

>>> rtl/core/sptmr_ram.sv
// ----------------------------------------------------------------------------
// sptmr_ram
// Simple dual-port memory: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sptmr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
